[sv/modular_exponentiation_macros.svh]
// assertion macros used by the modular exponentiation controller
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// property checked on every clock edge outside reset
`define MODEXP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define MODEXP_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/modexp_pkg.sv]
// shared types and constants for the modular exponentiation block
`timescale 1ns / 1ps
`default_nettype none

package modexp_pkg;

   // register reset values before trimming to the word width
   localparam logic [63:0] EXPONENT_RESET = 64'd65537;
   localparam logic [63:0] MODULUS_RESET  = 64'd9173503;
   // smallest modulus the block will hold
   localparam logic [63:0] MODULUS_MIN    = 64'd2;

   // register indexes on the csr port
   localparam logic REG_EXPONENT = 1'b0;
   localparam logic REG_MODULUS  = 1'b1;

   // where a finished modular product is written
   typedef enum logic [1:0] {
      DST_NONE = 2'b00,
      DST_BASE = 2'b01,
      DST_R    = 2'b10
   } modexp_dst_type;

   // controller to datapath commands
   typedef struct packed {
      logic           load;      // new item: start reduction, copy exponent
      logic           step;      // one add-and-double step of the multiplier
      logic           setup_sq;  // operands r, r
      logic           setup_mul; // operands r, base
      modexp_dst_type dst;       // destination of the product on its last step
      logic           e_shift;   // move to the next exponent bit
      logic           out_load;  // copy r into the output register
   } modexp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic e_msb;               // current exponent bit
   } modexp_status_type;

endpackage

`default_nettype wire

[sv/modexp_ifs.sv]
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface modexp_req_if #(parameter int unsigned WORD_BITS = 32);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface modexp_rsp_if #(parameter int unsigned WORD_BITS = 32);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] result;

   modport source (output valid, output result, input ready);
   modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

[sv/modexp_csr.sv]
// apb-style register file holding exponent and modulus
`timescale 1ns / 1ps
`default_nettype none

module modexp_csr
   import modexp_pkg::*;
#(
   parameter int unsigned WORD_BITS,
   parameter int unsigned DATA_BITS,
   parameter int unsigned ADDR_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [DATA_BITS-1:0] csr_pwdata,
   output logic      [DATA_BITS-1:0] csr_prdata,
   output logic                      csr_pready,
   output logic      [WORD_BITS-1:0] exponent,
   output logic      [WORD_BITS-1:0] modulus
);

   localparam logic [WORD_BITS-1:0] EXP_RESET = WORD_BITS'(EXPONENT_RESET);
   localparam logic [WORD_BITS-1:0] MOD_MIN   = WORD_BITS'(MODULUS_MIN);
   localparam logic [WORD_BITS-1:0] MOD_RAW   = WORD_BITS'(MODULUS_RESET);
   localparam logic [WORD_BITS-1:0] MOD_RESET = (MOD_RAW < MOD_MIN) ? MOD_MIN : MOD_RAW;

   logic [WORD_BITS-1:0] exponent_ff, exponent_in;
   logic [WORD_BITS-1:0] modulus_ff, modulus_in;
   logic                 wr_en;
   logic                 reg_sel;
   logic [WORD_BITS-1:0] wdata;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[ADDR_BITS-1];
   assign wdata      = WORD_BITS'(csr_pwdata);

   // register write decode, modulus held at two or more
   always_comb begin
      exponent_in = exponent_ff;
      modulus_in  = modulus_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_EXPONENT: begin
               exponent_in = wdata;
            end
            REG_MODULUS: begin
               modulus_in = (wdata < MOD_MIN) ? MOD_MIN : wdata;
            end
            default: begin
               exponent_in = exponent_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exponent_ff <= EXP_RESET;
         modulus_ff  <= MOD_RESET;
      end else begin
         exponent_ff <= exponent_in;
         modulus_ff  <= modulus_in;
      end
   end

   // read mux
   always_comb begin
      case (reg_sel)
         REG_EXPONENT: csr_prdata = DATA_BITS'(exponent_ff);
         REG_MODULUS:  csr_prdata = DATA_BITS'(modulus_ff);
         default:      csr_prdata = '0;
      endcase
   end

   assign exponent = exponent_ff;
   assign modulus  = modulus_ff;

endmodule

`default_nettype wire

[sv/modexp_dp.sv]
// datapath: bit-serial modular multiplier, operand and result registers
`timescale 1ns / 1ps
`default_nettype none

module modexp_dp
   import modexp_pkg::*;
#(
   parameter int unsigned WORD_BITS
) (
   input  wire logic                 clock,
   input  wire modexp_cmd_type       cmd,
   output modexp_status_type         status,
   input  wire logic [WORD_BITS-1:0] value,
   input  wire logic [WORD_BITS-1:0] exponent,
   input  wire logic [WORD_BITS-1:0] modulus,
   output logic      [WORD_BITS-1:0] result
);

   logic [WORD_BITS-1:0] a_ff, a_in;       // multiplicand
   logic [WORD_BITS-1:0] b_ff, b_in;       // multiplier, scanned from the top
   logic [WORD_BITS-1:0] acc_ff, acc_in;   // running product
   logic [WORD_BITS-1:0] base_ff, base_in; // reduced input value
   logic [WORD_BITS-1:0] r_ff, r_in;       // exponentiation result
   logic [WORD_BITS-1:0] e_ff, e_in;       // exponent, scanned from the top
   logic [WORD_BITS-1:0] result_ff, result_in;

   logic [WORD_BITS:0]   dbl_sum;
   logic [WORD_BITS-1:0] dbl;
   logic [WORD_BITS-1:0] addend;
   logic [WORD_BITS:0]   add_sum;
   logic [WORD_BITS-1:0] acc_next;

   // one step: acc = 2*acc mod m, then add a mod m when the b bit is set
   always_comb begin
      dbl_sum  = {acc_ff, 1'b0};
      dbl      = (dbl_sum >= {1'b0, modulus}) ? WORD_BITS'(dbl_sum - {1'b0, modulus})
                                              : WORD_BITS'(dbl_sum);
      addend   = b_ff[WORD_BITS-1] ? a_ff : '0;
      add_sum  = {1'b0, dbl} + {1'b0, addend};
      acc_next = (add_sum >= {1'b0, modulus}) ? WORD_BITS'(add_sum - {1'b0, modulus})
                                              : WORD_BITS'(add_sum);
   end

   // register updates by command
   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      r_in      = r_ff;
      e_in      = e_ff;
      result_in = result_ff;
      if (cmd.load) begin
         // reduction is a product with multiplicand one
         a_in   = WORD_BITS'(1);
         b_in   = value;
         acc_in = '0;
         e_in   = exponent;
         r_in   = WORD_BITS'(1);
      end else if (cmd.setup_sq) begin
         a_in   = r_ff;
         b_in   = r_ff;
         acc_in = '0;
      end else if (cmd.setup_mul) begin
         a_in   = r_ff;
         b_in   = base_ff;
         acc_in = '0;
      end else if (cmd.step) begin
         acc_in = acc_next;
         b_in   = {b_ff[WORD_BITS-2:0], 1'b0};
      end
      case (cmd.dst)
         DST_BASE: base_in = acc_next;
         DST_R:    r_in    = acc_next;
         default:  base_in = base_ff;
      endcase
      if (cmd.e_shift) begin
         e_in = {e_ff[WORD_BITS-2:0], 1'b0};
      end
      if (cmd.out_load) begin
         result_in = r_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      acc_ff    <= acc_in;
      base_ff   <= base_in;
      r_ff      <= r_in;
      e_ff      <= e_in;
      result_ff <= result_in;
   end

   assign status.e_msb = e_ff[WORD_BITS-1];
   assign result       = result_ff;

endmodule

`default_nettype wire

[sv/modexp_ctrl.sv]
// controller: sequences reduction, squares and multiplies, owns the handshakes
`timescale 1ns / 1ps
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modexp_ctrl
   import modexp_pkg::*;
#(
   parameter int unsigned WORD_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output modexp_cmd_type   cmd,
   input  wire modexp_status_type status
);

   localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WORD_BITS - 1);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_REDUCE    = 7'b0000010,
      ST_SQ_SETUP  = 7'b0000100,
      ST_SQ_RUN    = 7'b0001000,
      ST_MUL_SETUP = 7'b0010000,
      ST_MUL_RUN   = 7'b0100000,
      ST_FINISH    = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] step_cnt_ff, step_cnt_in;
   logic [CNT_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                step_last;
   logic                bit_last;

   assign step_last = (step_cnt_ff == CNT_LAST);
   assign bit_last  = (bit_cnt_ff == CNT_LAST);

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      bit_cnt_in  = bit_cnt_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.dst     = DST_NONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load    = 1'b1;
               step_cnt_in = '0;
               bit_cnt_in  = '0;
               state_in    = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd.step    = 1'b1;
            step_cnt_in = step_cnt_ff + 1'b1;
            if (step_last) begin
               cmd.dst     = DST_BASE;
               step_cnt_in = '0;
               state_in    = ST_SQ_SETUP;
            end
         end
         ST_SQ_SETUP: begin
            cmd.setup_sq = 1'b1;
            state_in     = ST_SQ_RUN;
         end
         ST_SQ_RUN: begin
            cmd.step    = 1'b1;
            step_cnt_in = step_cnt_ff + 1'b1;
            if (step_last) begin
               cmd.dst     = DST_R;
               step_cnt_in = '0;
               if (status.e_msb) begin
                  state_in = ST_MUL_SETUP;
               end else begin
                  cmd.e_shift = 1'b1;
                  bit_cnt_in  = bit_cnt_ff + 1'b1;
                  state_in    = bit_last ? ST_FINISH : ST_SQ_SETUP;
               end
            end
         end
         ST_MUL_SETUP: begin
            cmd.setup_mul = 1'b1;
            state_in      = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            cmd.step    = 1'b1;
            step_cnt_in = step_cnt_ff + 1'b1;
            if (step_last) begin
               cmd.dst     = DST_R;
               cmd.e_shift = 1'b1;
               step_cnt_in = '0;
               bit_cnt_in  = bit_cnt_ff + 1'b1;
               state_in    = bit_last ? ST_FINISH : ST_SQ_SETUP;
            end
         end
         ST_FINISH: begin
            // hand off once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   `MODEXP_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid_ff && state_ff == ST_IDLE), "reset did not clear controller")
   `MODEXP_ASSERT(a_accept_starts, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_REDUCE && step_cnt_ff == '0), "accepted transfer did not start reduction")
   `MODEXP_ASSERT(a_no_overwrite, clock, reset, cmd.out_load |-> (!rsp_valid_ff || rsp_ready), "output register overwritten before transfer")
   `MODEXP_ASSERT(a_cnt_range, clock, reset, (step_cnt_ff <= CNT_LAST) && (bit_cnt_ff <= CNT_LAST), "counter past word width")

endmodule

`default_nettype wire

[sv/modular_exponentiation.sv]
// top level: value^exponent mod modulus by square-and-multiply
//
//   channel   direction  transfer / access
//   req_chan  in         value, on valid & ready
//   rsp_chan  out        result, on valid & ready
//   csr_*     in/out     apb read and write of exponent (index 0) or modulus (index 1)
//
// one item at a time; the bit-serial modular multiplier does one add-and-double
// step per cycle.
// the next item is taken while a finished result still waits on rsp_chan.
// synchronous reset restores exponent 65537 and modulus 9173503, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module modular_exponentiation
   import modexp_pkg::*;
#(
   parameter  int unsigned WORD_BITS = 32,
   localparam int unsigned DATA_BITS = (WORD_BITS > 32) ? 64 : 32,
   localparam int unsigned ADDR_BITS = (WORD_BITS > 32) ? 4 : 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   modexp_req_if.sink                req_chan,
   modexp_rsp_if.source              rsp_chan,
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [ADDR_BITS-1:0] csr_paddr,
   input  wire logic [DATA_BITS-1:0] csr_pwdata,
   output logic      [DATA_BITS-1:0] csr_prdata,
   output logic                      csr_pready
);

   logic [WORD_BITS-1:0] exponent;
   logic [WORD_BITS-1:0] modulus;
   modexp_cmd_type       cmd;
   modexp_status_type    status;

   // configuration registers
   modexp_csr #(
      .WORD_BITS (WORD_BITS),
      .DATA_BITS (DATA_BITS),
      .ADDR_BITS (ADDR_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .exponent    (exponent),
      .modulus     (modulus)
   );

   // sequencer
   modexp_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic
   modexp_dp #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .status   (status),
      .value    (req_chan.value),
      .exponent (exponent),
      .modulus  (modulus),
      .result   (rsp_chan.result)
   );

endmodule

`default_nettype wire
